// ===== design/vfst_pkg.sv =====
// shared constants and types for the video frame statistics tracker
// no dependencies
package vfst_pkg;

    localparam int FRAME_SLOTS = 64;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);

    localparam int BYTES_W = 26;
    localparam int CODE_W  = 5;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 6;
    localparam int DUR_W   = 6;
    localparam int KB_W    = 8;
    localparam int TYPE_W  = 2;

    localparam int S_DATA_W = 64;
    localparam int S_USER_W = CODE_W;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = TYPE_W;

    typedef logic [TYPE_W-1:0] frame_type_t;
    localparam frame_type_t TYPE_P     = 2'd0;
    localparam frame_type_t TYPE_I     = 2'd1;
    localparam frame_type_t TYPE_OTHER = 2'd2;

    localparam logic [CODE_W-1:0] CODE_P = 5'd1;
    localparam logic [CODE_W-1:0] CODE_I = 5'd5;

    localparam logic [DUR_W-1:0] DUR_MAX = 6'd63;
    localparam logic [DUR_W-1:0] DUR_MIN = 6'd1;
    localparam logic [KB_W-1:0]  KB_MAX  = 8'd255;
    localparam logic [BYTES_W-1:0] KB_BYTES = 26'd1000;

    // bytes / 1000 = (bytes >> 3) / 125, reciprocal of 125 scaled by 2^30
    localparam int                KB_SHIFT = 30;
    localparam logic [23:0]       KB_RECIP = 24'd8589935;
    // n / 3 for n below 2^28, reciprocal of 3 scaled by 2^29
    localparam int                DIV3_SHIFT = 29;
    localparam logic [27:0]       DIV3_RECIP = 28'd178956971;

endpackage

// ===== design/video_frame_stats_tracker.sv =====
// video frame statistics tracker: frame ring position, clamped interval,
// kilobyte size and running i/p frame size averages; depends on vfst_pkg
//
// usage
//   s_* channel: one beat per finished frame (byte size, time stamp in tdata,
//   codec unit type code in tuser). m_* channel: one result beat per frame
//   with the slot it filled, its type, interval, kilobyte size, both running
//   averages and the slot that becomes current.
//   path: an accepted beat goes through the input register, then the result
//   register, before it shows on m_tvalid.
//   throughput: one beat per cycle while m_tready is high; the averages, slot
//   index and last time stamp are updated in the cycle that moves an item from
//   the input register to the result register, so beats may follow back to back.
//   reset: slot 0 current and typed as p frame, no earlier time stamp, both
//   averages zero; both registers empty.
//   stall: while m_tready is low the result holds; the input register still
//   takes one more beat, then s_tready drops until the result is taken.
//   no per-slot duration or size store is kept beyond the reported values.
module video_frame_stats_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_bytes[25:0], time_now[57:26], zero[63:58]
    input  logic [vfst_pkg::S_DATA_W-1:0] s_tdata,
    // frame_type_code[4:0]
    input  logic [vfst_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // done_slot[5:0], done_duration_ms[11:6], done_size_kb[19:12],
    // avg_i_bytes[45:20], avg_p_bytes[71:46], next_slot[77:72], zero[79:78]
    output logic [vfst_pkg::M_DATA_W-1:0] m_tdata,
    // done_type[1:0]
    output logic [vfst_pkg::M_USER_W-1:0] m_tuser
);
    import vfst_pkg::*;

    // input register
    logic                 in_valid_reg;
    logic [BYTES_W-1:0]   in_bytes_reg;
    logic [CODE_W-1:0]    in_code_reg;
    logic [TIME_W-1:0]    in_time_reg;

    // block state
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    frame_type_t          cur_type_reg;
    frame_type_t          cur_type_next;
    logic [TIME_W-1:0]    last_time_reg;
    logic [BYTES_W-1:0]   avg_i_reg;
    logic [BYTES_W-1:0]   avg_i_next;
    logic [BYTES_W-1:0]   avg_p_reg;
    logic [BYTES_W-1:0]   avg_p_next;

    // result register
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [M_DATA_W-1:0]  out_data_next;
    frame_type_t          out_type_reg;

    logic                 advance;
    logic                 move;

    logic [TIME_W-1:0]    diff;
    logic [DUR_W-1:0]     dur;
    logic [46:0]          kb_prod;
    logic [16:0]          kb_full;
    logic [KB_W-1:0]      kb;
    logic                 big_frame;
    logic [27:0]          i_sum;
    logic [28:0]          p_sum;
    logic [55:0]          p_prod;
    logic [25:0]          p_quot;

    assign advance  = !out_valid_reg || m_tready;
    assign move     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_type_reg;

    always_comb
    begin
        // clamped frame interval
        diff = in_time_reg - last_time_reg;
        if (last_time_reg == '0)
        begin
            dur = DUR_MIN;
        end
        else if (diff > TIME_W'(DUR_MAX))
        begin
            dur = DUR_MAX;
        end
        else if (diff == '0)
        begin
            dur = DUR_MIN;
        end
        else
        begin
            dur = diff[DUR_W-1:0];
        end

        // kilobytes by reciprocal multiply
        kb_prod = 47'(in_bytes_reg[BYTES_W-1:3]) * 47'(KB_RECIP);
        kb_full = kb_prod[KB_SHIFT +: 17];
        kb      = (kb_full > 17'(KB_MAX)) ? KB_MAX : kb_full[KB_W-1:0];
        big_frame = (in_bytes_reg >= KB_BYTES);

        // running averages
        i_sum  = 28'({avg_i_reg, 1'b0}) + 28'(avg_i_reg) + 28'(in_bytes_reg);
        p_sum  = 29'({avg_p_reg, 2'b00}) + 29'(avg_p_reg) + 29'(in_bytes_reg);
        p_prod = 56'(p_sum[28:1]) * 56'(DIV3_RECIP);
        p_quot = p_prod[DIV3_SHIFT +: 26];

        avg_i_next = avg_i_reg;
        avg_p_next = avg_p_reg;
        if (big_frame && cur_type_reg == TYPE_I)
        begin
            avg_i_next = (avg_i_reg == '0) ? in_bytes_reg : i_sum[27:2];
        end
        else if (big_frame && cur_type_reg == TYPE_P)
        begin
            avg_p_next = (avg_p_reg == '0) ? in_bytes_reg : p_quot;
        end

        // ring advance and type stamp
        if (slot_reg == SLOT_W'(FRAME_SLOTS - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end

        unique case (in_code_reg)
            CODE_P:  cur_type_next = TYPE_P;
            CODE_I:  cur_type_next = TYPE_I;
            default: cur_type_next = TYPE_OTHER;
        endcase

        out_data_next = {2'b00, IDX_W'(slot_next), avg_p_next, avg_i_next, kb, dur,
                         IDX_W'(slot_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            cur_type_reg  <= TYPE_P;
            last_time_reg <= '0;
            avg_i_reg     <= '0;
            avg_p_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move)
            begin
                slot_reg      <= slot_next;
                cur_type_reg  <= cur_type_next;
                last_time_reg <= in_time_reg;
                avg_i_reg     <= avg_i_next;
                avg_p_reg     <= avg_p_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_bytes_reg <= s_tdata[BYTES_W-1:0];
            in_time_reg  <= s_tdata[BYTES_W +: TIME_W];
            in_code_reg  <= s_tuser;
        end
        if (move)
        begin
            out_data_reg <= out_data_next;
            out_type_reg <= cur_type_reg;
        end
    end

    // input register is full whenever the slave side is held off
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("s_tready low with room in the pipeline");

    // ring state only moves with an item
    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(slot_reg) && $stable(avg_i_reg) && $stable(avg_p_reg))
        else $error("tracker state changed without an item");

    // reported interval is always within range
    a_dur_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[11:6] != '0)
        else $error("zero frame interval reported");

    // at most one running average changes per item
    a_one_avg: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> $stable(avg_i_reg) || $stable(avg_p_reg))
        else $error("both averages changed on one item");

    // kilobyte size zero exactly for small frames
    a_kb_small: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> ((kb == '0) == !big_frame))
        else $error("kilobyte size disagrees with small frame check");

endmodule
